// ----- hw/rtl/rounded_moving_average_defines.svh -----
// Assertion helpers used by rounded_moving_average.sv.
`ifndef ROUNDED_MOVING_AVERAGE_DEFINES_SVH
`define ROUNDED_MOVING_AVERAGE_DEFINES_SVH

// Checked at every edge once reset is released.
`define RMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define RMA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hw/rtl/rma_pkg.sv -----
package rma_pkg;

  localparam int MAX_LENGTH   = 64;
  localparam int RESET_LENGTH = 16;
  localparam int SAMPLE_W     = 16;
  localparam int CFG_LEN_W    = 7;
  localparam int ADDR_W       = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int LEN_W        = $clog2(MAX_LENGTH + 1);
  localparam int SUM_W        = SAMPLE_W + ADDR_W + 1;
  localparam int CNT_W        = $clog2(SUM_W + 1);

  localparam logic CFG_WINDOW_LENGTH = 1'b0;
  localparam logic CFG_INITIAL_VALUE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV,
    ST_DONE
  } rma_state_e;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [LEN_W-1:0] divisor;
  } rma_div_req_t;

endpackage

// ----- hw/rtl/rounded_moving_average.sv -----
// Channel   Direction  Signals
// sample    in         sample_valid_i, sample_ready_o, sample_i
// average   out        average_valid_o, average_ready_i, average_o
// cfg       in         cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
//
// Each sample goes through these steps in order: read the history memory, update
// the sum, SUM_W divider steps, see the divider finish and load the output register.
// Reset clears the window at once through per-slot valid bits; no sweep.
// One sample is in flight at a time; a full output register stalls it until taken.
// Config words are taken while no sample is in flight.
`include "rounded_moving_average_defines.svh"

module rounded_moving_average (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           sample_valid_i,
  output logic                           sample_ready_o,
  input  logic signed [15:0]             sample_i,
  output logic                           average_valid_o,
  input  logic                           average_ready_i,
  output logic signed [15:0]             average_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [15:0]                    cfg_data_i
);

  localparam int SW = rma_pkg::SAMPLE_W;
  localparam int AW = rma_pkg::ADDR_W;
  localparam int LW = rma_pkg::LEN_W;
  localparam int UW = rma_pkg::SUM_W;
  localparam int CFG_LEN_W_T = rma_pkg::CFG_LEN_W;

  rma_pkg::rma_state_e state_q, state_d;

  logic signed [SW-1:0] hist_mem [rma_pkg::MAX_LENGTH];
  logic signed [SW-1:0] rd_data_q;
  logic [rma_pkg::MAX_LENGTH-1:0] slot_valid_q, slot_valid_d;

  logic [LW-1:0]        len_q, len_d;
  logic [AW-1:0]        pos_q, pos_d;
  logic signed [UW-1:0] sum_q, sum_d;
  logic signed [SW-1:0] fill_q, fill_d;
  logic signed [SW-1:0] mean_q, mean_d;
  logic signed [SW-1:0] sample_q;
  logic                 neg_q;
  logic signed [SW-1:0] avg_q;
  logic                 out_valid_q, out_valid_d;

  logic                 in_acc, cfg_acc, out_free;
  logic                 mem_re, mem_we, load_out;
  logic [CFG_LEN_W_T-1:0] len_raw;
  logic [LW-1:0]        len_clamp;
  logic signed [SW-1:0] old_val;
  logic signed [UW-1:0] new_sum, new_mag, refill_sum, refill_val, refill_len;
  logic [UW-1:0]        half;
  logic signed [SW-1:0] quo_signed;

  rma_pkg::rma_div_req_t div_req;
  logic                  div_busy, div_done;
  logic [UW-1:0]         div_quo;

  rma_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign in_acc   = sample_valid_i && sample_ready_o;
  assign cfg_acc  = cfg_valid_i && cfg_ready_o;
  assign out_free = !out_valid_q || average_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rma_pkg::ST_IDLE:   if (in_acc) state_d = rma_pkg::ST_UPDATE;
      rma_pkg::ST_UPDATE: state_d = rma_pkg::ST_DIV;
      rma_pkg::ST_DIV:    if (div_done) state_d = rma_pkg::ST_DONE;
      rma_pkg::ST_DONE:   if (out_free) state_d = rma_pkg::ST_IDLE;
      default:            state_d = rma_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    sample_ready_o = 1'b0;
    cfg_ready_o    = 1'b0;
    mem_re         = 1'b0;
    mem_we         = 1'b0;
    load_out       = 1'b0;
    case (state_q)
      rma_pkg::ST_IDLE: begin
        sample_ready_o = 1'b1;
        cfg_ready_o    = 1'b1;
        mem_re         = in_acc;
      end
      rma_pkg::ST_UPDATE: mem_we = 1'b1;
      rma_pkg::ST_DIV:    ;
      rma_pkg::ST_DONE:   load_out = out_free;
      default:            ;
    endcase
  end

  // an unwritten slot reads as the last fill value
  assign old_val = slot_valid_q[pos_q] ? rd_data_q : fill_q;
  assign new_sum = sum_q - UW'(old_val) + UW'(sample_q);
  assign new_mag = new_sum[UW-1] ? -new_sum : new_sum;
  assign half    = UW'(len_q >> 1);

  assign div_req.start    = mem_we;
  assign div_req.dividend = UW'(new_mag) + half;
  assign div_req.divisor  = len_q;

  assign quo_signed = neg_q ? -div_quo[SW-1:0] : div_quo[SW-1:0];

  // clamp the requested length to 1..MAX_LENGTH
  assign len_raw = cfg_data_i[CFG_LEN_W_T-1:0];
  always_comb begin
    if (len_raw == '0) begin
      len_clamp = LW'(1);
    end else if (int'(len_raw) > rma_pkg::MAX_LENGTH) begin
      len_clamp = LW'(rma_pkg::MAX_LENGTH);
    end else begin
      len_clamp = LW'(len_raw);
    end
  end

  always_comb begin
    if (cfg_index_i == rma_pkg::CFG_WINDOW_LENGTH) begin
      refill_val = UW'(mean_q);
      refill_len = UW'(len_clamp);
    end else begin
      refill_val = UW'($signed(cfg_data_i));
      refill_len = UW'(len_q);
    end
  end
  assign refill_sum = refill_val * refill_len;

  // register updates
  always_comb begin
    len_d        = len_q;
    pos_d        = pos_q;
    sum_d        = sum_q;
    fill_d       = fill_q;
    mean_d       = mean_q;
    slot_valid_d = slot_valid_q;
    out_valid_d  = out_valid_q;
    if (out_valid_q && average_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cfg_acc) begin
      if (cfg_index_i == rma_pkg::CFG_INITIAL_VALUE || len_clamp != len_q) begin
        len_d        = (cfg_index_i == rma_pkg::CFG_WINDOW_LENGTH) ? len_clamp : len_q;
        pos_d        = '0;
        sum_d        = refill_sum;
        fill_d       = refill_val[SW-1:0];
        mean_d       = refill_val[SW-1:0];
        slot_valid_d = '0;
      end
    end
    if (mem_we) begin
      sum_d               = new_sum;
      slot_valid_d[pos_q] = 1'b1;
      // advance, wrapping at the window length
      if ({1'b0, pos_q} + 1'b1 >= (AW + 1)'(len_q)) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
    if (load_out) begin
      mean_d      = quo_signed;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rma_pkg::ST_IDLE;
      len_q        <= LW'(rma_pkg::RESET_LENGTH);
      pos_q        <= '0;
      sum_q        <= '0;
      fill_q       <= '0;
      mean_q       <= '0;
      slot_valid_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      len_q        <= len_d;
      pos_q        <= pos_d;
      sum_q        <= sum_d;
      fill_q       <= fill_d;
      mean_q       <= mean_d;
      slot_valid_q <= slot_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= sample_i;
    end
    if (mem_we) begin
      neg_q <= new_sum[UW-1];
    end
    if (load_out) begin
      avg_q <= quo_signed;
    end
  end

  // history memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[pos_q] <= sample_q;
    end
    if (mem_re) begin
      rd_data_q <= hist_mem[pos_q];
    end
  end

  assign average_valid_o = out_valid_q;
  assign average_o       = avg_q;

  `RMA_ASSERT(a_pos_in_window, (AW + 1)'(pos_q) < (AW + 1)'(len_q), "write slot outside window")
  `RMA_ASSERT(a_len_range, len_q != '0 && int'(len_q) <= rma_pkg::MAX_LENGTH, "length out of range")
  `RMA_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == rma_pkg::ST_DONE), "average loaded outside done")
  `RMA_ASSERT(a_div_running, state_q == rma_pkg::ST_DIV |-> div_busy || div_done, "divider idle while waited on")

endmodule

// ----- hw/rtl/rma_divider.sv -----
module rma_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rma_pkg::rma_div_req_t      req_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [rma_pkg::SUM_W-1:0]  quotient_o
);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [rma_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [rma_pkg::SUM_W-1:0]  quo_q, quo_d;
  logic [rma_pkg::LEN_W-1:0]  rem_q, rem_d;
  logic [rma_pkg::LEN_W-1:0]  div_q, div_d;
  logic [rma_pkg::LEN_W:0]    rem_sh;
  logic                       ge;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh = {rem_q, quo_q[rma_pkg::SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = rma_pkg::CNT_W'(rma_pkg::SUM_W);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? rma_pkg::LEN_W'(rem_sh - {1'b0, div_q}) : rem_sh[rma_pkg::LEN_W-1:0];
      quo_d = {quo_q[rma_pkg::SUM_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == rma_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- tb/rounded_moving_average_tb.sv -----
`timescale 1ns / 1ps

module rounded_moving_average_tb;

  localparam int SETTLE_CYCLES = rma_pkg::SUM_W + 12;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASES        = 16;
  localparam int PHASE_ITEMS   = 122;

  // Boxcar average of the window, with the pending averages in order.
  class window_average_model;
    shortint             slots[rma_pkg::MAX_LENGTH];
    longint              total;
    int                  wpos;
    int                  len;
    logic signed [15:0]  preset_value;
    logic signed [15:0]  averages_due[$];
    int                  errors;

    function new();
      foreach (slots[i]) slots[i] = 0;
      total        = 0;
      wpos         = 0;
      len          = rma_pkg::RESET_LENGTH;
      preset_value = '0;
      errors       = 0;
    endfunction

    function longint mean();
      longint half;
      half = len / 2;
      if (total < 0) return (total - half) / len;
      return (total + half) / len;
    endfunction

    function void fill(shortint v, int n);
      len   = n;
      wpos  = 0;
      total = longint'(v) * n;
      for (int i = 0; i < n; i++) slots[i] = v;
    endfunction

    function void write_reg(logic idx, logic [15:0] data);
      int n;
      if (idx == rma_pkg::CFG_WINDOW_LENGTH) begin
        n = int'(data[rma_pkg::CFG_LEN_W-1:0]);
        if (n < 1) n = 1;
        if (n > rma_pkg::MAX_LENGTH) n = rma_pkg::MAX_LENGTH;
        if (n != len) fill(shortint'(mean()), n);
      end else begin
        preset_value = data;
        fill(preset_value, len);
      end
    endfunction

    function void take_sample(logic signed [15:0] s);
      logic signed [15:0] avg;
      total = total - slots[wpos];
      slots[wpos] = s;
      total = total + s;
      wpos++;
      if (wpos >= len) wpos = 0;
      avg = 16'(mean());
      averages_due.push_back(avg);
    endfunction

    function void check_average(logic signed [15:0] got);
      logic signed [15:0] want;
      if (averages_due.size() == 0) begin
        $error("average: no word expected, actual %0d", got);
        errors++;
      end else begin
        want = averages_due.pop_front();
        if (got !== want) begin
          $error("average: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return averages_due.size();
    endfunction
  endclass

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               sample_valid_i  = 1'b0;
  logic               sample_ready_o;
  logic signed [15:0] sample_i        = '0;
  logic               average_valid_o;
  logic               average_ready_i = 1'b0;
  logic signed [15:0] average_o;
  logic               cfg_valid_i     = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i     = 1'b0;
  logic [15:0]        cfg_data_i      = '0;

  window_average_model model_h = new();
  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  int                  cycle_count    = 0;

  rounded_moving_average dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sample_valid_i  (sample_valid_i),
    .sample_ready_o  (sample_ready_o),
    .sample_i        (sample_i),
    .average_valid_o (average_valid_o),
    .average_ready_i (average_ready_i),
    .average_o       (average_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    average_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (average_valid_o && average_ready_i) model_h.check_average(average_o);
      if (sample_valid_i && sample_ready_o) model_h.take_sample(sample_i);
      if (cfg_valid_i && cfg_ready_o) model_h.write_reg(cfg_index_i, cfg_data_i);
    end
  end

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
      default: begin send_idle_pct = 38; recv_stall_pct = 38; end
    endcase
  endtask

  task automatic send_sample(input logic [15:0] value);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      sample_valid_i <= 1'b0;
      repeat ($urandom_range(40, 1)) @(posedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_i       <= value;
    do @(posedge clk_i); while (!sample_ready_o);
  endtask

  // Drop the sample valid, drain every pending average, then settle.
  task automatic drain();
    sample_valid_i <= 1'b0;
    @(posedge clk_i);
    while (model_h.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic idx, input logic [15:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_sample(logic [15:0] base);
    logic [15:0] v;
    case ($urandom_range(9))
      0: v = 16'h7FFF;
      1: v = 16'h8000;
      2, 3: v = base + 16'($urandom_range(2)) - 16'd1;
      4: v = 16'($urandom_range(6)) - 16'd3;
      default: v = 16'($urandom());
    endcase
    return v;
  endfunction

  initial begin
    logic [6:0]  len_field;
    logic [15:0] init_word;
    logic [15:0] base;

    set_idling(0);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes at the reset length.
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    // Zero length clamps to one; bits above the length field are ignored.
    write_register(rma_pkg::CFG_WINDOW_LENGTH, 16'hFF80);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    // Oversized length clamps to the full window.
    write_register(rma_pkg::CFG_WINDOW_LENGTH, 16'h0064);
    write_register(rma_pkg::CFG_INITIAL_VALUE, 16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h7FFF);
    // Two slots: rounding ties on both signs.
    write_register(rma_pkg::CFG_WINDOW_LENGTH, 16'h0002);
    write_register(rma_pkg::CFG_INITIAL_VALUE, 16'h0000);
    send_sample(16'h0001);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'hFFFE);
    send_sample(16'h0003);
    write_register(rma_pkg::CFG_INITIAL_VALUE, 16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0005);
    // Length change refills with the current average.
    write_register(rma_pkg::CFG_WINDOW_LENGTH, 16'h0003);
    send_sample(16'h0001);
    send_sample(16'h0001);
    // Same length again leaves the window alone.
    write_register(rma_pkg::CFG_WINDOW_LENGTH, 16'h0003);
    send_sample(16'hFFFF);

    for (int p = 0; p < PHASES; p++) begin
      case (p % 8)
        0: len_field = 7'd0;
        1: len_field = 7'd64;
        2: len_field = 7'd2;
        3: len_field = 7'($urandom_range(127, 65));
        5: len_field = 7'd1;
        6: len_field = 7'(model_h.len);
        default: len_field = 7'($urandom_range(64, 1));
      endcase
      case ($urandom_range(3))
        0: init_word = 16'h7FFF;
        1: init_word = 16'h8000;
        default: init_word = 16'($urandom());
      endcase
      if ($urandom_range(1)) begin
        write_register(rma_pkg::CFG_WINDOW_LENGTH, {9'($urandom()), len_field});
        write_register(rma_pkg::CFG_INITIAL_VALUE, init_word);
      end else begin
        write_register(rma_pkg::CFG_INITIAL_VALUE, init_word);
        write_register(rma_pkg::CFG_WINDOW_LENGTH, {9'($urandom()), len_field});
      end
      set_idling(p);
      base = 16'($urandom());
      for (int i = 0; i < PHASE_ITEMS; i++) send_sample(pick_sample(base));
      set_idling(0);
    end

    drain();
    if (model_h.errors == 0 && model_h.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/rma_pkg.sv
hw/rtl/rma_divider.sv
hw/rtl/rounded_moving_average.sv
tb/rounded_moving_average_tb.sv
